### sv/mscomp_pkg.sv
`default_nettype none
package mscomp_pkg;

    localparam int FRAC_BITS_DEF = 4;

    // quotient magnitude bits kept by the divider (saturates above)
    localparam int QBITS = 17;
    localparam int DIV_LAT = QBITS + 1;

    localparam int FRONT_STAGES = 6;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_NONE  = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_XY_OFFSETS = 3'd0,
        REG_XY_CURVE   = 3'd1,
        REG_Z_GAIN     = 3'd2,
        REG_Z_BASE     = 3'd3,
        REG_Z_SLOPE    = 3'd4,
        REG_Z_OFFSET   = 3'd5,
        REG_HALL_REF   = 3'd6
    } cfg_idx_t;

endpackage
`default_nettype wire

### sv/magnetometer_sample_compensation.sv
`default_nettype none
// Magnetometer sample compensation.
// Input stream (s_axis_*): one transfer carries a four-word burst from the
// sensor: x, y, z and hall/ready words. Output stream (m_axis_*): one
// transfer per input with the body-frame field (forward, right, down) in
// 2^-FRAC_BITS microtesla and a status code (valid, no new sample, invalid).
// Trim registers are loaded over the wr_* port, one register per cycle; the
// user must load them only while the stream is idle, as the block does not enforce it.
// Pipeline: 25 register stages: six arithmetic stages (unpack, products, hall
// polynomial, split partial products, sum, rounding offset), 18 stages of the
// bit-per-stage divider, one output register. Throughput: one transfer per cycle
// while the receiver does not stall.
// The whole pipe advances on one enable; when the receiver stalls with a
// result waiting, s_axis_tready drops and every stage holds.
// Reset clears the trim registers to zero and empties the pipe.
module magnetometer_sample_compensation #(
    parameter int FRAC_BITS = mscomp_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x_word[15:0], y_word[31:16], z_word[47:32], hall_word[63:48]
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // body_forward[17:0], body_right[35:18], body_down[53:36], status[55:54]
    output logic [55:0]      m_axis_tdata,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [31:0] wr_data
);
    import mscomp_pkg::*;

    localparam int XW  = 70 + FRAC_BITS;     // xy dividend width
    localparam int ZW  = 52 + FRAC_BITS;     // z dividend width
    localparam int NST = FRONT_STAGES + DIV_LAT;

    // ---------------- trim registers ----------------
    logic [31:0] xy_off_reg;
    logic [15:0] xy_curve_reg;
    logic [15:0] z_gain_reg;
    logic [15:0] z_base_reg;
    logic [15:0] z_slope_reg;
    logic [15:0] z_off_reg;
    logic [15:0] hall_ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xy_off_reg   <= '0;
            xy_curve_reg <= '0;
            z_gain_reg   <= '0;
            z_base_reg   <= '0;
            z_slope_reg  <= '0;
            z_off_reg    <= '0;
            hall_ref_reg <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_XY_OFFSETS: xy_off_reg   <= wr_data;
                REG_XY_CURVE:   xy_curve_reg <= wr_data[15:0];
                REG_Z_GAIN:     z_gain_reg   <= wr_data[15:0];
                REG_Z_BASE:     z_base_reg   <= wr_data[15:0];
                REG_Z_SLOPE:    z_slope_reg  <= wr_data[15:0];
                REG_Z_OFFSET:   z_off_reg    <= wr_data[15:0];
                REG_HALL_REF:   hall_ref_reg <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    logic signed [7:0] off_x, off_y, gain_x, gain_y, xy2;
    logic signed [8:0] xy1;
    logic signed [9:0] g160_x, g160_y;

    assign off_x  = $signed(xy_off_reg[7:0]);
    assign off_y  = $signed(xy_off_reg[15:8]);
    assign gain_x = $signed(xy_off_reg[23:16]);
    assign gain_y = $signed(xy_off_reg[31:24]);
    assign xy1    = $signed({1'b0, xy_curve_reg[7:0]});
    assign xy2    = $signed(xy_curve_reg[15:8]);
    assign g160_x = 10'(gain_x) + 10'sd160;
    assign g160_y = 10'(gain_y) + 10'sd160;

    // ---------------- pipe control ----------------
    logic    ce;
    logic    pv_reg  [1:NST];
    status_t pst_reg [1:NST];
    logic    out_valid_reg;
    logic [55:0] out_data_reg;

    assign ce            = ~out_valid_reg | m_axis_tready;
    assign s_axis_tready = ce;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NST; k++)
                pv_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            pv_reg[1] <= s_axis_tvalid;
            for (int k = 2; k <= NST; k++)
                pv_reg[k] <= pv_reg[k-1];
            out_valid_reg <= pv_reg[NST];
        end
    end

    // ---------------- P1: unpack ----------------
    logic signed [12:0] rx1_reg, ry1_reg;
    logic signed [14:0] rz1_reg;
    logic        [13:0] hall1_reg;
    logic        [15:0] h1_reg;       // hall, or the reference when hall is zero
    logic        [13:0] in_hall;

    assign in_hall = s_axis_tdata[63:50];

    // ---------------- P2: products ----------------
    logic signed [16:0] dd;
    logic        [31:0] hh2_reg;
    logic signed [33:0] dd2_reg, dh2_reg;
    logic signed [22:0] mx2_reg, my2_reg;
    logic signed [16:0] zd2_reg;
    logic signed [32:0] z3p2_reg;
    logic signed [32:0] zden2_reg;
    logic               bad2;

    assign dd   = $signed({1'b0, hall_ref_reg}) - $signed({1'b0, h1_reg});
    assign bad2 = (h1_reg == '0) || (rx1_reg == -13'sd4096) || (ry1_reg == -13'sd4096)
                  || (rz1_reg == -15'sd16384) || (hall1_reg == '0)
                  || (z_gain_reg == '0) || (z_base_reg == '0);

    // ---------------- P3: hall polynomial, z numerator ----------------
    logic signed [43:0] p3_reg;
    logic signed [40:0] ox3_reg, oy3_reg;
    logic        [31:0] hh3_reg;
    logic signed [22:0] mx3_reg, my3_reg;
    logic signed [34:0] nz;
    logic signed [35:0] zn3_reg;
    logic        [33:0] zdd3_reg;

    assign nz = (35'(zd2_reg) <<< 17) - 35'(z3p2_reg);

    // ---------------- P4: partial products ----------------
    logic signed [45:0] xlo4_reg, ylo4_reg;
    logic signed [44:0] xhi4_reg, yhi4_reg;
    logic signed [40:0] ox4_reg, oy4_reg;
    logic        [31:0] hh4_reg;
    logic signed [35:0] zn4_reg;
    logic        [33:0] zdd4_reg;

    // ---------------- P5: numerators ----------------
    logic signed [67:0] nx5_reg, ny5_reg;
    logic        [31:0] hh5_reg;
    logic signed [35:0] zn5_reg;
    logic        [33:0] zdd5_reg;

    // ---------------- P6: rounding offset ----------------
    logic signed [XW-1:0] nx6_reg, ny6_reg;
    logic        [XW-1:0] dxy6_reg;
    logic signed [ZW-1:0] nz6_reg;
    logic        [ZW-1:0] dz6_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // P1
            rx1_reg   <= $signed(s_axis_tdata[15:3]);
            ry1_reg   <= $signed(s_axis_tdata[31:19]);
            rz1_reg   <= $signed(s_axis_tdata[47:33]);
            hall1_reg <= in_hall;
            h1_reg    <= (in_hall == '0) ? hall_ref_reg : {2'b00, in_hall};
            pst_reg[1] <= s_axis_tdata[48] ? ST_VALID : ST_NONE;

            // P2
            hh2_reg   <= h1_reg * h1_reg;
            dd2_reg   <= 34'(dd) * 34'(dd);
            dh2_reg   <= 34'(dd) * 34'($signed({1'b0, h1_reg}));
            mx2_reg   <= 23'(rx1_reg) * 23'(g160_x);
            my2_reg   <= 23'(ry1_reg) * 23'(g160_y);
            zd2_reg   <= 17'(rz1_reg) - 17'($signed(z_off_reg));
            z3p2_reg  <= 33'($signed(z_slope_reg))
                         * (33'($signed({1'b0, hall1_reg})) - 33'($signed({1'b0, hall_ref_reg})));
            zden2_reg <= (33'($signed(z_base_reg)) <<< 15)
                         + 33'($signed({1'b0, z_gain_reg * 30'(hall1_reg)}));
            pst_reg[2] <= (pst_reg[1] == ST_NONE) ? ST_NONE : (bad2 ? ST_BAD : ST_VALID);

            // P3
            p3_reg   <= 44'(xy2) * 44'(dd2_reg) + 44'(xy1) * 44'(dh2_reg)
                        + 44'($signed({1'b0, hh2_reg, 8'b0}));
            ox3_reg  <= 41'(off_x) * 41'($signed({1'b0, hh2_reg}));
            oy3_reg  <= 41'(off_y) * 41'($signed({1'b0, hh2_reg}));
            hh3_reg  <= hh2_reg;
            mx3_reg  <= mx2_reg;
            my3_reg  <= my2_reg;
            zn3_reg  <= zden2_reg[32] ? -36'(nz) : 36'(nz);
            zdd3_reg <= zden2_reg[32] ? 34'(-zden2_reg) << 1 : 34'(zden2_reg) << 1;
            pst_reg[3] <= (pst_reg[2] == ST_VALID && zden2_reg == '0) ? ST_BAD : pst_reg[2];

            // P4
            xlo4_reg <= 46'(mx3_reg) * 46'($signed({1'b0, p3_reg[21:0]}));
            ylo4_reg <= 46'(my3_reg) * 46'($signed({1'b0, p3_reg[21:0]}));
            xhi4_reg <= 45'(mx3_reg) * 45'($signed(p3_reg[43:22]));
            yhi4_reg <= 45'(my3_reg) * 45'($signed(p3_reg[43:22]));
            ox4_reg  <= ox3_reg;
            oy4_reg  <= oy3_reg;
            hh4_reg  <= hh3_reg;
            zn4_reg  <= zn3_reg;
            zdd4_reg <= zdd3_reg;

            // P5
            nx5_reg  <= (68'(xhi4_reg) <<< 22) + 68'(xlo4_reg) + (68'(ox4_reg) <<< 16);
            ny5_reg  <= (68'(yhi4_reg) <<< 22) + 68'(ylo4_reg) + (68'(oy4_reg) <<< 16);
            hh5_reg  <= hh4_reg;
            zn5_reg  <= zn4_reg;
            zdd5_reg <= zdd4_reg;

            // P6: N = num * 2^(sh+1) + den, floor(N / (2*den)) rounds half up
            dxy6_reg <= XW'({hh5_reg, 18'b0});
            nx6_reg  <= (XW'(nx5_reg) <<< (FRAC_BITS + 1)) + XW'($signed({1'b0, hh5_reg, 17'b0}));
            ny6_reg  <= (XW'(ny5_reg) <<< (FRAC_BITS + 1)) + XW'($signed({1'b0, hh5_reg, 17'b0}));
            nz6_reg  <= (ZW'(zn5_reg) <<< (FRAC_BITS + 10))
                        + ZW'($signed({2'b00, zdd5_reg[33:1]}));
            dz6_reg  <= ZW'(zdd5_reg);

            for (int k = 4; k <= NST; k++)
                pst_reg[k] <= pst_reg[k-1];
        end
    end

    // ---------------- dividers ----------------
    // floor of a negative N is taken as ~floor(~N / D)
    logic [QBITS-1:0] qx, qy, qz;
    logic             negx, negy, negz;

    mscomp_div #(.W(XW)) u_div_x (
        .clk(clk), .ce(ce),
        .num(nx6_reg[XW-1] ? ~nx6_reg : nx6_reg), .den(dxy6_reg),
        .neg_in(nx6_reg[XW-1]), .quo(qx), .neg_out(negx)
    );

    mscomp_div #(.W(XW)) u_div_y (
        .clk(clk), .ce(ce),
        .num(ny6_reg[XW-1] ? ~ny6_reg : ny6_reg), .den(dxy6_reg),
        .neg_in(ny6_reg[XW-1]), .quo(qy), .neg_out(negy)
    );

    mscomp_div #(.W(ZW)) u_div_z (
        .clk(clk), .ce(ce),
        .num(nz6_reg[ZW-1] ? ~nz6_reg : nz6_reg), .den(dz6_reg),
        .neg_in(nz6_reg[ZW-1]), .quo(qz), .neg_out(negz)
    );

    // ---------------- output register ----------------
    logic [17:0] cx, cz, fwd;
    logic [55:0] out_data_next;

    always_comb
    begin
        cx  = negx ? ~{1'b0, qx} : {1'b0, qx};
        cz  = negz ? ~{1'b0, qz} : {1'b0, qz};
        // forward = -chip y; -(-131072) saturates to 131071
        if (negy)
            fwd = (&qy) ? {1'b0, qy} : {1'b0, qy} + 18'd1;
        else
            fwd = 18'd0 - {1'b0, qy};
        if (pst_reg[NST] == ST_VALID)
            out_data_next = {pst_reg[NST], cz, cx, fwd};
        else
            out_data_next = {pst_reg[NST], 54'd0};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

### sv/mscomp_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage after the range-check stage.
// quo = min(floor(num / den), 2^QBITS - 1); num, den unsigned.
module mscomp_div #(
    parameter int W = 70
) (
    input  wire logic                     clk,
    input  wire logic                     ce,
    input  wire logic [W-1:0]             num,
    input  wire logic [W-1:0]             den,
    input  wire logic                     neg_in,
    output logic [mscomp_pkg::QBITS-1:0]  quo,
    output logic                          neg_out
);
    import mscomp_pkg::*;

    logic [W-1:0]     rem_reg [0:QBITS];
    logic [W-1:0]     den_reg [0:QBITS];
    logic [QBITS-1:0] q_reg   [0:QBITS];
    logic             ovf_reg [0:QBITS];
    logic             neg_reg [0:QBITS];

    // stage 0: range check against den * 2^QBITS
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num >= (den << QBITS));
            neg_reg[0] <= neg_in;
        end
    end

    for (genvar k = 1; k <= QBITS; k++)
    begin : g_stage
        localparam int SH = QBITS - k;
        logic [W:0]       diff;
        logic             ge;
        logic [QBITS-1:0] q_next;

        always_comb
        begin
            diff       = {1'b0, rem_reg[k-1]} - {1'b0, (den_reg[k-1] << SH)};
            ge         = ~diff[W];
            q_next     = q_reg[k-1];
            q_next[SH] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k] <= ge ? diff[W-1:0] : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= q_next;
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign quo     = ovf_reg[QBITS] ? '1 : q_reg[QBITS];
    assign neg_out = neg_reg[QBITS];

endmodule
`default_nettype wire
